// File: hdl/touchpad_motion_and_tap_engine_core_assert.svh
// Assertion macros for the touchpad engine core.
// Included by the modules that assert; no other dependencies.
`ifndef TOUCHPAD_MOTION_AND_TAP_ENGINE_CORE_ASSERT_SVH
`define TOUCHPAD_MOTION_AND_TAP_ENGINE_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define TPE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Implication with the consequent checked in the cycle after the antecedent.
`define TPE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// File: hdl/tpe_pkg.sv
// Package for the touchpad engine: result event type, kinds, register indexes.
// No dependencies.
`default_nettype none
package tpe_pkg;
   localparam logic [1:0] KIND_BUTTON = 2'd0;
   localparam logic [1:0] KIND_TOUCH  = 2'd1;
   localparam logic [1:0] KIND_REL_X  = 2'd2;
   localparam logic [1:0] KIND_REL_Y  = 2'd3;

   localparam logic [2:0] REG_TAPS_DIS  = 3'd0;
   localparam logic [2:0] REG_SMOOTH    = 3'd1;
   localparam logic [2:0] REG_FAST_TAP  = 3'd2;
   localparam logic [2:0] REG_TAP_DL    = 3'd3;
   localparam logic [2:0] REG_HOLD_BACK = 3'd4;
   localparam logic [2:0] REG_DRAG_BUD  = 3'd5;
   localparam logic [2:0] REG_DRAG_WIN  = 3'd6;
   localparam logic [2:0] REG_IDLE_LIFT = 3'd7;

   localparam int Q8_ONE   = 256;
   localparam int FAST_SUM = 4;
   localparam int QDEPTH   = 4;

   typedef struct packed {
      logic [1:0]        kind;
      logic [1:0]        key;
      logic signed [7:0] value;
      logic              sync;
      logic              last;
   } event_type;

   // Reciprocal gain table: 256 / s rounded down for s >= 2, constant over ranges of s.
   function automatic logic [7:0] inv_gain(input logic [7:0] s);
      logic [7:0] r;
      case (s) inside
         8'd0, 8'd1, 8'd2: r = 8'd128;
         8'd3:             r = 8'd85;
         8'd4:             r = 8'd64;
         8'd5:             r = 8'd51;
         8'd6:             r = 8'd42;
         8'd7:             r = 8'd36;
         8'd8:             r = 8'd32;
         8'd9:             r = 8'd28;
         8'd10:            r = 8'd25;
         8'd11:            r = 8'd23;
         8'd12:            r = 8'd21;
         8'd13:            r = 8'd19;
         8'd14:            r = 8'd18;
         8'd15:            r = 8'd17;
         8'd16:            r = 8'd16;
         8'd17:            r = 8'd15;
         8'd18:            r = 8'd14;
         8'd19:            r = 8'd13;
         [8'd20:8'd21]:    r = 8'd12;
         [8'd22:8'd23]:    r = 8'd11;
         [8'd24:8'd25]:    r = 8'd10;
         [8'd26:8'd28]:    r = 8'd9;
         [8'd29:8'd32]:    r = 8'd8;
         [8'd33:8'd36]:    r = 8'd7;
         [8'd37:8'd42]:    r = 8'd6;
         [8'd43:8'd51]:    r = 8'd5;
         [8'd52:8'd64]:    r = 8'd4;
         [8'd65:8'd85]:    r = 8'd3;
         [8'd86:8'd128]:   r = 8'd2;
         default:          r = 8'd1;
      endcase
      return r;
   endfunction

   function automatic logic signed [7:0] clamp8(input logic signed [16:0] v);
      if (v > 17'sd127) return 8'sd127;
      if (v < -17'sd128) return -8'sd128;
      return v[7:0];
   endfunction
endpackage
`default_nettype wire

// File: hdl/tpe_front.sv
// Front end: takes a report, runs the per-report state update, emits event beats.
// Depends on tpe_pkg and the assertion macros header. Events go out one a cycle into the event queue while it has room.
`default_nettype none
module tpe_front #(
   parameter int TIME_BITS    = 32,
   parameter int BUTTON_COUNT = 3
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   output logic                    busy,
   input  wire [2:0]               in_buttons,
   input  wire                     in_touching,
   input  wire signed [7:0]        in_dx,
   input  wire signed [7:0]        in_dy,
   input  wire [31:0]              in_now,
   input  wire                     taps_disabled,
   input  wire [7:0]               smooth_div,
   input  wire                     fast_tap_enable,
   input  wire [15:0]              tap_deadline_ms,
   input  wire [15:0]              hold_back_ms,
   input  wire [15:0]              drag_budget,
   input  wire [15:0]              drag_window_ms,
   input  wire [7:0]               idle_reports_for_lift,
   output logic                    ev_valid,
   output tpe_pkg::event_type      ev_data,
   input  wire                     ev_ready
);
   import tpe_pkg::*;
   localparam int TB = TIME_BITS;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_TOUCH = 6'b000010,
      S_GAIN  = 6'b000100,
      S_SMTH  = 6'b001000,
      S_FAST  = 6'b010000,
      S_EMIT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // persistent state
   logic [2:0]          button_cache_ff, button_cache_in;
   logic [7:0]          idle_count_ff, idle_count_in;
   logic signed [9:0]   rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [TB-1:0]       start_time_ff, start_time_in;
   logic signed [15:0]  held_x_ff, held_x_in, held_y_ff, held_y_in;
   logic [15:0]         msum_ff, msum_in;
   logic                hold_ff, hold_in, tapp_ff, tapp_in, drag_ff, drag_in;
   logic [TB-1:0]       click_time_ff, click_time_in;
   logic                click_rec_ff, click_rec_in;

   // per-report working registers
   logic [2:0]          btn_ff, btn_in;
   logic                tch_ff, tch_in;
   logic signed [7:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic [TB-1:0]       now_ff, now_in;
   logic                changed_ff, changed_in, send_ff, send_in;
   logic [8:0]          gain_ff, gain_in;

   // event slot list built up during the report
   event_type           slot_ff [8];
   event_type           slot_in [8];
   logic [3:0]          cnt_ff, cnt_in;
   logic [3:0]          rd_ff, rd_in;

   assign busy = (state_ff != S_IDLE);

   function automatic event_type mk(input logic [1:0] k, input logic [1:0] ky,
                                    input logic signed [7:0] v, input logic s);
      event_type e;
      e.kind = k; e.key = ky; e.value = v; e.sync = s; e.last = 1'b0;
      return e;
   endfunction

   // Per-state logic.
   always_comb begin
      logic [7:0]         lo;
      logic [2:0]         tot;
      logic signed [17:0] accx, accy;
      logic signed [9:0]  qx, qy;
      logic [TB-1:0]      dur, cdiff;
      logic [16:0]        m;
      logic signed [16:0] hx, hy;
      logic [3:0]         c;
      state_in = state_ff;
      button_cache_in = button_cache_ff; idle_count_in = idle_count_ff;
      rem_x_in = rem_x_ff; rem_y_in = rem_y_ff; start_time_in = start_time_ff;
      held_x_in = held_x_ff; held_y_in = held_y_ff; msum_in = msum_ff;
      hold_in = hold_ff; tapp_in = tapp_ff; drag_in = drag_ff;
      click_time_in = click_time_ff; click_rec_in = click_rec_ff;
      btn_in = btn_ff; tch_in = tch_ff; dx_in = dx_ff; dy_in = dy_ff; now_in = now_ff;
      changed_in = changed_ff; send_in = send_ff; gain_in = gain_ff;
      slot_in = slot_ff; cnt_in = cnt_ff; rd_in = rd_ff;
      lo = '0; tot = '0; accx = '0; accy = '0; qx = '0; qy = '0;
      dur = '0; cdiff = '0; m = '0; hx = '0; hy = '0; c = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               btn_in = in_buttons; tch_in = in_touching;
               dx_in = in_dx; dy_in = in_dy; now_in = TB'(in_now);
               cnt_in = '0; rd_in = '0; send_in = 1'b0; changed_in = 1'b0;
               state_in = S_TOUCH;
            end
         end
         // button changes and touch tracking
         S_TOUCH: begin
            c = '0;
            if (!taps_disabled && (btn_ff != 3'd0 || button_cache_ff != 3'd0)) begin
               for (int i = 0; i < BUTTON_COUNT; i++) begin
                  if (btn_ff[i] != button_cache_ff[i]) begin
                     slot_in[c[2:0]] = mk(KIND_BUTTON, 2'(i), {7'd0, btn_ff[i]}, 1'b0);
                     c = c + 4'd1;
                     send_in = 1'b1;
                  end
               end
            end
            button_cache_in = btn_ff;
            if (tch_ff) begin
               send_in = 1'b1;
               if (idle_count_ff != 8'd0) begin
                  changed_in = 1'b1; idle_count_in = '0;
                  dx_in = '0; dy_in = '0; rem_x_in = '0; rem_y_in = '0;
               end
            end else begin
               if (idle_count_ff != 8'd255) begin
                  idle_count_in = idle_count_ff + 8'd1;
                  if (idle_count_in == idle_reports_for_lift) changed_in = 1'b1;
               end
               dx_in = '0; dy_in = '0;
            end
            if (changed_in) begin
               slot_in[c[2:0]] = mk(KIND_TOUCH, 2'd0, {7'd0, tch_ff}, 1'b0);
               c = c + 4'd1;
               send_in = 1'b1;
            end
            cnt_in = c;
            state_in = S_GAIN;
         end
         // gain, then one multiply per axis
         S_GAIN: begin
            if ((dx_ff < 0 ? -int'(dx_ff) : int'(dx_ff)) +
                (dy_ff < 0 ? -int'(dy_ff) : int'(dy_ff)) >= FAST_SUM) begin
               gain_in = 9'(Q8_ONE);
            end else begin
               lo = inv_gain(smooth_div);
               tot = 3'((dx_ff < 0 ? -int'(dx_ff) : int'(dx_ff)) +
                        (dy_ff < 0 ? -int'(dy_ff) : int'(dy_ff)));
               gain_in = 9'({1'b0, lo} + 9'(((11'(Q8_ONE) - 11'(lo)) * 11'(tot)) >> 2));
            end
            state_in = S_SMTH;
         end
         S_SMTH: begin
            if (smooth_div >= 8'd2) begin
               accx = 18'(rem_x_ff) + 18'(dx_ff) * $signed({9'd0, gain_ff});
               accy = 18'(rem_y_ff) + 18'(dy_ff) * $signed({9'd0, gain_ff});
               qx = 10'(accx / 18'sd256);
               qy = 10'(accy / 18'sd256);
               rem_x_in = 10'(accx - 18'(qx) * 18'sd256);
               rem_y_in = 10'(accy - 18'(qy) * 18'sd256);
               dx_in = clamp8(17'(qx));
               dy_in = clamp8(17'(qy));
            end
            state_in = S_FAST;
         end
         // fast-tap logic and trailing rel events
         S_FAST: begin
            if (fast_tap_enable) begin
               if (changed_ff && tch_ff) begin
                  start_time_in = now_ff; held_x_in = '0; held_y_in = '0; msum_in = '0;
                  hold_in = 1'b1; tapp_in = 1'b1;
                  cdiff = now_ff - click_time_ff;
                  if (click_rec_ff && cdiff < TB'(drag_window_ms)) begin
                     slot_in[c[2:0]] = mk(KIND_BUTTON, 2'd0, 8'sd1, 1'b0);
                     c = c + 4'd1;
                     drag_in = 1'b1; hold_in = 1'b0; tapp_in = 1'b0;
                  end
                  click_rec_in = 1'b0;
               end
               if (tch_ff && (hold_in || tapp_in)) begin
                  dur = now_ff - start_time_in;
                  m = 17'(msum_in) + 17'(dx_in < 0 ? -int'(dx_in) : int'(dx_in)) +
                      17'(dy_in < 0 ? -int'(dy_in) : int'(dy_in));
                  msum_in = m[16] ? 16'hFFFF : m[15:0];
                  hx = 17'(held_x_in) + 17'(dx_in);
                  hy = 17'(held_y_in) + 17'(dy_in);
                  held_x_in = (hx > 17'sd32767) ? 16'sh7FFF :
                              (hx < -17'sd32768) ? 16'sh8000 : hx[15:0];
                  held_y_in = (hy > 17'sd32767) ? 16'sh7FFF :
                              (hy < -17'sd32768) ? 16'sh8000 : hy[15:0];
                  if (msum_in > drag_budget || dur > TB'(tap_deadline_ms))
                     tapp_in = 1'b0;
                  if (hold_in) begin
                     if (msum_in > drag_budget ||
                         (msum_in != 16'd0 && dur > TB'(hold_back_ms))) begin
                        dx_in = clamp8(17'(held_x_in));
                        dy_in = clamp8(17'(held_y_in));
                        hold_in = 1'b0;
                     end else begin
                        dx_in = '0; dy_in = '0;
                     end
                  end
               end
               if (changed_ff && !tch_ff) begin
                  if (drag_ff) begin
                     slot_in[c[2:0]] = mk(KIND_BUTTON, 2'd0, 8'sd0, 1'b0);
                     c = c + 4'd1;
                     drag_in = 1'b0;
                  end else if (tapp_in) begin
                     slot_in[c[2:0]] = mk(KIND_BUTTON, 2'd0, 8'sd1, 1'b1);
                     slot_in[c[2:0] + 3'd1] = mk(KIND_BUTTON, 2'd0, 8'sd0, 1'b1);
                     c = c + 4'd2;
                     click_time_in = now_ff; click_rec_in = 1'b1;
                  end
                  hold_in = 1'b0; tapp_in = 1'b0;
               end
            end
            if (send_ff) begin
               slot_in[c[2:0]] = mk(KIND_REL_X, 2'd0, dx_in, 1'b0);
               slot_in[c[2:0] + 3'd1] = mk(KIND_REL_Y, 2'd0, dy_in, 1'b1);
               c = c + 4'd2;
            end
            cnt_in = c;
            state_in = (c == 4'd0) ? S_IDLE : S_EMIT;
         end
         // hand one beat a cycle to the queue while it is ready
         S_EMIT: begin
            if (ev_ready) begin
               rd_in = rd_ff + 4'd1;
               if (rd_in == cnt_ff) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ev_valid = (state_ff == S_EMIT);
      ev_data = slot_ff[rd_ff[2:0]];
      ev_data.last = (rd_ff + 4'd1 == cnt_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         button_cache_ff <= '0; idle_count_ff <= '0; rem_x_ff <= '0; rem_y_ff <= '0;
         start_time_ff <= '0; held_x_ff <= '0; held_y_ff <= '0; msum_ff <= '0;
         hold_ff <= 1'b0; tapp_ff <= 1'b0; drag_ff <= 1'b0;
         click_time_ff <= '0; click_rec_ff <= 1'b0;
         cnt_ff <= '0; rd_ff <= '0;
      end else begin
         state_ff <= state_in;
         button_cache_ff <= button_cache_in; idle_count_ff <= idle_count_in;
         rem_x_ff <= rem_x_in; rem_y_ff <= rem_y_in; start_time_ff <= start_time_in;
         held_x_ff <= held_x_in; held_y_ff <= held_y_in; msum_ff <= msum_in;
         hold_ff <= hold_in; tapp_ff <= tapp_in; drag_ff <= drag_in;
         click_time_ff <= click_time_in; click_rec_ff <= click_rec_in;
         cnt_ff <= cnt_in; rd_ff <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      btn_ff <= btn_in; tch_ff <= tch_in; dx_ff <= dx_in; dy_ff <= dy_in;
      now_ff <= now_in; changed_ff <= changed_in; send_ff <= send_in;
      gain_ff <= gain_in;
      slot_ff <= slot_in;
   end

   `include "touchpad_motion_and_tap_engine_core_assert.svh"
   `TPE_ASSERT_IMP(a_cnt_max, clock, reset, 1'b1, cnt_ff <= 4'd8, "more than eight events")
   `TPE_ASSERT_IMP(a_emit_rd, clock, reset, state_ff == S_EMIT, rd_ff < cnt_ff,
      "read past event list")
   `TPE_ASSERT_IMP(a_state_onehot, clock, reset, 1'b1, $onehot(state_ff),
      "state not one-hot")
endmodule
`default_nettype wire

// File: hdl/tpe_back.sv
// Back end: event queue between the front end and the result ports.
// Depends on tpe_pkg and the assertion macros header.
`default_nettype none
module tpe_back (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 wr_valid,
   input  tpe_pkg::event_type  wr_data,
   output logic                wr_ready,
   output logic                rd_empty,
   output tpe_pkg::event_type  rd_data,
   input  wire                 rd_pop
);
   import tpe_pkg::*;
   localparam int AW = $clog2(QDEPTH);

   event_type        mem_ff [QDEPTH];
   logic [AW-1:0]    wp_ff, rp_ff;
   logic [AW:0]      cnt_ff;
   logic             push, pop;

   assign wr_ready = (cnt_ff != (AW+1)'(QDEPTH));
   assign rd_empty = (cnt_ff == '0);
   assign rd_data  = mem_ff[rp_ff];
   assign push = wr_valid && wr_ready;
   assign pop  = rd_pop && !rd_empty;

   // store beat
   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= wr_data;
   end

   // advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + AW'(1);
         if (pop) rp_ff <= rp_ff + AW'(1);
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end

   `include "touchpad_motion_and_tap_engine_core_assert.svh"
   `TPE_ASSERT_IMP(a_cnt_range, clock, reset, 1'b1, cnt_ff <= (AW+1)'(QDEPTH),
      "queue overfilled")
   `TPE_ASSERT_NEXT(a_pop_only, clock, reset, pop && !push, cnt_ff == $past(cnt_ff) - 1'b1,
      "pop did not drain")
   `TPE_ASSERT_NEXT(a_push_only, clock, reset, push && !pop, cnt_ff == $past(cnt_ff) + 1'b1,
      "push did not fill")
endmodule
`default_nettype wire

// File: hdl/touchpad_motion_and_tap_engine_core.sv
// Top level of the touchpad engine: registers, front end, event queue.
// Depends on tpe_pkg, tpe_front, tpe_back.
//
//  channel | ports                       | beat taken when
//  req     | req_* push full             | push && !full
//  rsp     | rsp_* empty pop             | pop && !empty
//  csr     | csr_valid csr_ready csr_*   | csr_valid && csr_ready
//
// A report passes through the front-end states touch, gain, smooth and fast-tap,
// then hands its event beats (0..8) to the queue, stalling while the queue is
// full; the next report is taken once the front end is idle again.
// The front end is one report at a time; full is high while it works.
// The four-deep event queue lets result stalls hold back only the front end.
// Reset is synchronous; all but per-report data and queue storage return to defaults.
`default_nettype none
module touchpad_motion_and_tap_engine_core #(
   parameter int TIME_BITS    = 32,
   parameter int BUTTON_COUNT = 3
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   output logic              full,
   input  wire [2:0]         req_buttons,
   input  wire               req_touching,
   input  wire signed [7:0]  req_delta_x,
   input  wire signed [7:0]  req_delta_y,
   input  wire [31:0]        req_now_ms,
   output logic              empty,
   input  wire               pop,
   output logic [1:0]        rsp_event_kind,
   output logic [1:0]        rsp_key_index,
   output logic signed [7:0] rsp_event_value,
   output logic              rsp_sync,
   output logic              rsp_last,
   input  wire               csr_valid,
   output logic              csr_ready,
   input  wire [2:0]         csr_index,
   input  wire [15:0]        csr_data
);
   import tpe_pkg::*;

   logic        taps_dis_ff, fast_ff;
   logic [7:0]  smooth_ff, lift_ff;
   logic [15:0] tap_dl_ff, hold_ff, bud_ff, win_ff;
   logic        busy, ev_valid, ev_ready;
   event_type   ev_data, rsp;

   assign csr_ready = 1'b1;
   assign full = busy;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         taps_dis_ff <= 1'b0; smooth_ff <= '0; fast_ff <= 1'b0;
         tap_dl_ff <= 16'd250; hold_ff <= 16'd120; bud_ff <= 16'd25;
         win_ff <= 16'd150; lift_ff <= 8'd3;
      end else if (csr_valid) begin
         case (csr_index)
            REG_TAPS_DIS:  taps_dis_ff <= csr_data[0];
            REG_SMOOTH:    smooth_ff <= csr_data[7:0];
            REG_FAST_TAP:  fast_ff <= csr_data[0];
            REG_TAP_DL:    tap_dl_ff <= csr_data;
            REG_HOLD_BACK: hold_ff <= csr_data;
            REG_DRAG_BUD:  bud_ff <= csr_data;
            REG_DRAG_WIN:  win_ff <= csr_data;
            REG_IDLE_LIFT: lift_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   tpe_front #(.TIME_BITS(TIME_BITS), .BUTTON_COUNT(BUTTON_COUNT)) u_front (
      .clock(clock), .reset(reset), .start(push && !busy), .busy(busy),
      .in_buttons(req_buttons), .in_touching(req_touching),
      .in_dx(req_delta_x), .in_dy(req_delta_y), .in_now(req_now_ms),
      .taps_disabled(taps_dis_ff), .smooth_div(smooth_ff),
      .fast_tap_enable(fast_ff), .tap_deadline_ms(tap_dl_ff),
      .hold_back_ms(hold_ff), .drag_budget(bud_ff), .drag_window_ms(win_ff),
      .idle_reports_for_lift(lift_ff),
      .ev_valid(ev_valid), .ev_data(ev_data), .ev_ready(ev_ready));

   tpe_back u_back (
      .clock(clock), .reset(reset), .wr_valid(ev_valid), .wr_data(ev_data),
      .wr_ready(ev_ready), .rd_empty(empty), .rd_data(rsp), .rd_pop(pop));

   assign rsp_event_kind  = rsp.kind;
   assign rsp_key_index   = rsp.key;
   assign rsp_event_value = rsp.value;
   assign rsp_sync        = rsp.sync;
   assign rsp_last        = rsp.last;
endmodule
`default_nettype wire
